// ===== design/cqg_pkg.sv =====
// ----------------------------------------------------------------------------
// cqg_pkg
// Shared types, codes and arithmetic helpers of the controlled gate update.
// ----------------------------------------------------------------------------
package cqg_pkg;

	localparam int PART_W = 16;
	localparam int CPX_W  = 2 * PART_W;
	localparam int ACC_W  = 20;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_READ  = 2'd1,
		CMD_LEFT  = 2'd2,
		CMD_RIGHT = 2'd3
	} cmd_t;

	localparam logic [2:0] REG_COEF_00   = 3'd0;
	localparam logic [2:0] REG_COEF_01   = 3'd1;
	localparam logic [2:0] REG_COEF_10   = 3'd2;
	localparam logic [2:0] REG_COEF_11   = 3'd3;
	localparam logic [2:0] REG_ROW_COUNT = 3'd4;
	localparam logic [2:0] REG_COL_COUNT = 3'd5;

	localparam logic [31:0] COEF_ONE  = 32'h4000_0000;
	localparam logic [5:0]  COUNT_RST = 6'd32;

	function automatic logic [PART_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
		logic [PART_W-1:0] r;
		if (v > 20'sd32767) begin
			r = 16'h7FFF;
		end else if (v < -20'sd32768) begin
			r = 16'h8000;
		end else begin
			r = v[PART_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== design/controlled_qubit_gate_matrix_update.sv =====
// ----------------------------------------------------------------------------
// controlled_qubit_gate_matrix_update
// Complex Q2.14 matrix store with element write/read and in-place 2x2 kernel
// application on row pairs (left) or column pairs (right), optional control.
// ----------------------------------------------------------------------------
// Write and read: S_ACK or S_RDOUT registers the result once the output is free.
// Apply: S_PAIR visits each outer index; each updated element pair passes through
//   the store reads (S_RDE, S_RDF), the shared complex multiplier (S_MAC) and the
//   store writes (S_WRE, S_WRF); a zeroed pair takes only the store writes.
// One command in flight; the single-port-per-side store sets the pace.
// Reset restores kernel and counts; store contents stay undefined until written.
module controlled_qubit_gate_matrix_update #(
	parameter int MAX_ROWS = 32,
	parameter int MAX_COLS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [4:0]  row,
	input  logic [4:0]  col,
	input  logic signed [15:0] wr_re,
	input  logic signed [15:0] wr_im,
	input  logic [2:0]  target,
	input  logic signed [3:0] control,
	input  logic        deriv,
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [15:0] rd_re,
	output logic signed [15:0] rd_im,
	output logic        is_read,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import cqg_pkg::*;

	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = $clog2(DEPTH);

	typedef enum logic [3:0] {
		S_IDLE,
		S_RDOUT,
		S_ACK,
		S_PAIR,
		S_RDE,
		S_RDF,
		S_MAC,
		S_WRE,
		S_WRF
	} state_t;

	function automatic logic [AW-1:0] elem_addr(input logic [5:0] r, input logic [5:0] c);
		return AW'(int'(r) * MAX_COLS + int'(c));
	endfunction

	state_t state_q;

	logic [31:0] coef00_q, coef01_q, coef10_q, coef11_q;
	logic [5:0]  row_count_q, col_count_q;

	logic        out_valid_q, is_read_q;
	logic [15:0] rd_re_q, rd_im_q;

	logic        left_q, deriv_q, rd_ok_q, zero_q;
	logic [7:0]  step_q;
	logic [3:0]  ctrl_q;
	logic [5:0]  o_q, n_q;
	logic [2:0]  ph_q;

	logic [CPX_W-1:0] e_q, f_q;
	logic signed [31:0] pr_rr_s1, pr_ii_s1, pr_ri_s1, pr_ir_s1;
	logic signed [ACC_W-1:0] acc0_re_q, acc0_im_q, acc1_re_q, acc1_im_q;

	cmd_t        cmd_in;
	logic        in_xfer, out_free, cfg_wr, cmd_ok;
	logic [AW-1:0] cmd_addr, addr_e, addr_f;
	logic [5:0]  rows_eff, cols_eff, outer_lim, inner_lim, p6;
	logic [8:0]  p_w;
	logic [7:0]  o_ext;
	logic        pair_ok, gate;

	logic [31:0] mul_k, mul_x;
	logic signed [15:0] kr, ki, xr, xi;
	logic signed [32:0] sum_re, sum_im, bias_re, bias_im;
	logic signed [18:0] rnd_re, rnd_im;

	logic             ram_we, ram_re;
	logic [AW-1:0]    ram_waddr, ram_raddr;
	logic [CPX_W-1:0] ram_wdata, ram_rdata, res_e, res_f;

	assign cmd_in   = cmd_t'(cmd);
	assign in_ready = (state_q == S_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign cfg_wr   = psel && penable && pwrite;
	assign pready   = 1'b1;

	assign out_valid = out_valid_q;
	assign rd_re     = rd_re_q;
	assign rd_im     = rd_im_q;
	assign is_read   = is_read_q;

	assign cmd_ok   = (32'(row) < MAX_ROWS) && (32'(col) < MAX_COLS);
	assign cmd_addr = elem_addr({1'b0, row}, {1'b0, col});

	assign rows_eff  = (32'(row_count_q) > MAX_ROWS) ? 6'(MAX_ROWS) : row_count_q;
	assign cols_eff  = (32'(col_count_q) > MAX_COLS) ? 6'(MAX_COLS) : col_count_q;
	assign outer_lim = left_q ? rows_eff : cols_eff;
	assign inner_lim = left_q ? cols_eff : rows_eff;

	assign o_ext   = {2'b00, o_q};
	assign p_w     = {3'b000, o_q} + {1'b0, step_q};
	assign p6      = p_w[5:0];
	assign pair_ok = ((o_ext & step_q) == 8'd0) && (p_w < {3'b000, outer_lim});
	assign gate    = ctrl_q[3] || o_ext[ctrl_q[2:0]];

	assign addr_e = left_q ? elem_addr(o_q, n_q) : elem_addr(n_q, o_q);
	assign addr_f = left_q ? elem_addr(p6, n_q)  : elem_addr(n_q, p6);

	assign res_e = zero_q ? '0 : {sat16(acc0_re_q), sat16(acc0_im_q)};
	assign res_f = zero_q ? '0 : {sat16(acc1_re_q), sat16(acc1_im_q)};

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef00_q    <= COEF_ONE;
			coef01_q    <= '0;
			coef10_q    <= '0;
			coef11_q    <= COEF_ONE;
			row_count_q <= COUNT_RST;
			col_count_q <= COUNT_RST;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				REG_COEF_00:   coef00_q    <= pwdata;
				REG_COEF_01:   coef01_q    <= pwdata;
				REG_COEF_10:   coef10_q    <= pwdata;
				REG_COEF_11:   coef11_q    <= pwdata;
				REG_ROW_COUNT: row_count_q <= pwdata[5:0];
				REG_COL_COUNT: col_count_q <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_COEF_00:   prdata = coef00_q;
			REG_COEF_01:   prdata = coef01_q;
			REG_COEF_10:   prdata = coef10_q;
			REG_COEF_11:   prdata = coef11_q;
			REG_ROW_COUNT: prdata = {26'd0, row_count_q};
			REG_COL_COUNT: prdata = {26'd0, col_count_q};
			default:       prdata = '0;
		endcase
	end

	// store access
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_e;
		ram_wdata = res_e;
		ram_re    = 1'b0;
		ram_raddr = addr_e;
		unique case (state_q)
			S_IDLE: begin
				if (in_xfer && cmd_in == CMD_WRITE && cmd_ok) begin
					ram_we    = 1'b1;
					ram_waddr = cmd_addr;
					ram_wdata = {wr_re, wr_im};
				end
				if (in_xfer && cmd_in == CMD_READ) begin
					ram_re    = 1'b1;
					ram_raddr = cmd_addr;
				end
			end
			S_RDE: ram_re = 1'b1;
			S_RDF: begin
				ram_re    = 1'b1;
				ram_raddr = addr_f;
			end
			S_WRE: ram_we = 1'b1;
			S_WRF: begin
				ram_we    = 1'b1;
				ram_waddr = addr_f;
				ram_wdata = res_f;
			end
			default: ;
		endcase
	end

	cqg_ram #(
		.WIDTH (CPX_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// shared complex multiplier: k0*e, kb*f, kc*e, k3*f
	always_comb begin
		case (ph_q[1:0])
			2'd0: begin
				mul_k = coef00_q;
				mul_x = e_q;
			end
			2'd1: begin
				mul_k = left_q ? coef01_q : coef10_q;
				mul_x = f_q;
			end
			2'd2: begin
				mul_k = left_q ? coef10_q : coef01_q;
				mul_x = e_q;
			end
			default: begin
				mul_k = coef11_q;
				mul_x = f_q;
			end
		endcase
	end

	assign kr = mul_k[31:16];
	assign ki = mul_k[15:0];
	assign xr = mul_x[31:16];
	assign xi = mul_x[15:0];

	assign sum_re  = 33'(pr_rr_s1) - 33'(pr_ii_s1);
	assign sum_im  = 33'(pr_ri_s1) + 33'(pr_ir_s1);
	assign bias_re = sum_re + 33'sd8192;
	assign bias_im = sum_im + 33'sd8192;
	assign rnd_re  = bias_re[32:14];
	assign rnd_im  = bias_im[32:14];

	always_ff @(posedge clk) begin
		pr_rr_s1 <= kr * xr;
		pr_ii_s1 <= ki * xi;
		pr_ri_s1 <= kr * xi;
		pr_ir_s1 <= ki * xr;
		if (state_q == S_RDF) begin
			e_q <= ram_rdata;
		end
		if (state_q == S_MAC) begin
			case (ph_q)
				3'd0: f_q <= ram_rdata;
				3'd1: begin
					acc0_re_q <= ACC_W'(rnd_re);
					acc0_im_q <= ACC_W'(rnd_im);
				end
				3'd2: begin
					acc0_re_q <= acc0_re_q + ACC_W'(rnd_re);
					acc0_im_q <= acc0_im_q + ACC_W'(rnd_im);
				end
				3'd3: begin
					acc1_re_q <= ACC_W'(rnd_re);
					acc1_im_q <= ACC_W'(rnd_im);
				end
				3'd4: begin
					acc1_re_q <= acc1_re_q + ACC_W'(rnd_re);
					acc1_im_q <= acc1_im_q + ACC_W'(rnd_im);
				end
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			is_read_q   <= 1'b0;
			rd_re_q     <= '0;
			rd_im_q     <= '0;
			left_q      <= 1'b0;
			deriv_q     <= 1'b0;
			rd_ok_q     <= 1'b0;
			zero_q      <= 1'b0;
			step_q      <= '0;
			ctrl_q      <= '0;
			o_q         <= '0;
			n_q         <= '0;
			ph_q        <= '0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_RDOUT && state_q != S_ACK) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						left_q  <= (cmd_in == CMD_LEFT);
						deriv_q <= deriv;
						rd_ok_q <= cmd_ok;
						step_q  <= 8'd1 << target;
						ctrl_q  <= control;
						o_q     <= '0;
						unique case (cmd_in) inside
							CMD_WRITE:           state_q <= S_ACK;
							CMD_READ:            state_q <= S_RDOUT;
							CMD_LEFT, CMD_RIGHT: state_q <= S_PAIR;
							default:             state_q <= S_ACK;
						endcase
					end
				end
				S_RDOUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						is_read_q   <= 1'b1;
						rd_re_q     <= rd_ok_q ? ram_rdata[31:16] : 16'd0;
						rd_im_q     <= rd_ok_q ? ram_rdata[15:0] : 16'd0;
						state_q     <= S_IDLE;
					end
				end
				S_ACK: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						is_read_q   <= 1'b0;
						rd_re_q     <= '0;
						rd_im_q     <= '0;
						state_q     <= S_IDLE;
					end
				end
				S_PAIR: begin
					if (o_q >= outer_lim) begin
						state_q <= S_ACK;
					end else if (!pair_ok || inner_lim == 6'd0 ||
							(!gate && !(left_q && deriv_q))) begin
						o_q <= o_q + 6'd1;
					end else begin
						n_q     <= '0;
						zero_q  <= !gate;
						state_q <= gate ? S_RDE : S_WRE;
					end
				end
				S_RDE: state_q <= S_RDF;
				S_RDF: begin
					ph_q    <= '0;
					state_q <= S_MAC;
				end
				S_MAC: begin
					ph_q <= ph_q + 3'd1;
					if (ph_q == 3'd4) begin
						state_q <= S_WRE;
					end
				end
				S_WRE: state_q <= S_WRF;
				S_WRF: begin
					if ((7'(n_q) + 7'd1) >= 7'(inner_lim)) begin
						o_q     <= o_q + 6'd1;
						state_q <= S_PAIR;
					end else begin
						n_q     <= n_q + 6'd1;
						state_q <= zero_q ? S_WRE : S_RDE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== design/cqg_ram.sv =====
// ----------------------------------------------------------------------------
// cqg_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module cqg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/cqg_chk.sv =====
// ----------------------------------------------------------------------------
// cqg_chk
// Port-level checks of the controlled gate update, bound to the top level.
// ----------------------------------------------------------------------------
module cqg_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] rd_re,
	input logic [15:0] rd_im,
	input logic        is_read,
	input logic        psel,
	input logic        pwrite,
	input logic [4:0]  paddr,
	input logic [31:0] prdata,
	input logic        pready
);
	import cqg_pkg::*;

	// one command at a time: a transfer closes the input until its result
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while a command is in flight");

	a_ack_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_read |-> rd_re == 16'd0 && rd_im == 16'd0)
		else $error("acknowledge carries nonzero data");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(rd_re) && $stable(rd_im)
			&& $stable(is_read))
		else $error("result changed while stalled");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

	a_count_rd: assert property (@(posedge clk) disable iff (!arst_n)
		psel && !pwrite && (paddr[4:2] == REG_ROW_COUNT || paddr[4:2] == REG_COL_COUNT)
			|-> prdata[31:6] == 26'd0)
		else $error("count register reads wider than its field");

endmodule

bind controlled_qubit_gate_matrix_update cqg_chk u_cqg_chk (.*);

// ===== sim/controlled_qubit_gate_matrix_update_test.sv =====
// ----------------------------------------------------------------------------
// controlled_qubit_gate_matrix_update_test
// Self-checking bench: command transfers into the gate update block are
// predicted against a shadow copy of the complex matrix and kernel, and each
// result transfer is compared field by field. Phases switch the kernel and
// the used matrix size over APB between bursts of directed and random traffic.
// ----------------------------------------------------------------------------
module controlled_qubit_gate_matrix_update_test;
	timeunit 1ns;
	timeprecision 1ps;

	import cqg_pkg::*;

	localparam int STORE_ROWS  = 32;
	localparam int STORE_COLS  = 32;
	localparam int STORE_DEPTH = STORE_ROWS * STORE_COLS;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int LONG_HOLD   = 300;

	typedef struct packed {
		cmd_t               op;
		logic [4:0]         row;
		logic [4:0]         col;
		logic signed [15:0] wre;
		logic signed [15:0] wim;
		logic [2:0]         target;
		logic signed [3:0]  control;
		logic               deriv;
	} gate_cmd_t;

	typedef struct packed {
		logic signed [15:0] re;
		logic signed [15:0] im;
		logic               is_read;
	} gate_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         cmd = CMD_WRITE;
	logic [4:0]         row = '0;
	logic [4:0]         col = '0;
	logic signed [15:0] wr_re = '0;
	logic signed [15:0] wr_im = '0;
	logic [2:0]         target = '0;
	logic signed [3:0]  control = '0;
	logic               deriv = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [15:0] rd_re;
	logic signed [15:0] rd_im;
	logic               is_read;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [4:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;

	gate_cmd_t    gate_queue[$];
	gate_result_t pending_results[$];

	logic [31:0] shadow_matrix [STORE_DEPTH];
	logic [31:0] kernel_q [4];
	logic [5:0]  row_limit_q;
	logic [5:0]  col_limit_q;
	bit          written_map [STORE_DEPTH];

	logic in_fire = 1'b0;
	bit   quiet = 1'b0;
	int   send_gap = 0;
	int   sink_gap = 0;
	int   hold_left = 0;
	int   hold_served = 0;
	int   hold_requests = 0;
	int   error_count = 0;
	int   cycle_count = 0;

	controlled_qubit_gate_matrix_update #(
		.MAX_ROWS(STORE_ROWS),
		.MAX_COLS(STORE_COLS)
	) i_dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("controlled_qubit_gate_matrix_update regression: fail");
			$finish;
		end
	end

	function automatic void flag_error(string msg);
		error_count++;
		if (error_count <= 10) begin
			$display("%0t ns: %s", $time, msg);
		end
	endfunction

	// ------------------------------------------------------------------
	// Q2.14 arithmetic and gate update on the shadow matrix
	// ------------------------------------------------------------------
	function automatic longint q14_round(longint v);
		return (v + 64'sd8192) >>> 14;
	endfunction

	function automatic logic [15:0] q14_clamp(longint v);
		logic [15:0] r;
		if (v > 32767) begin
			r = 16'h7FFF;
		end else if (v < -32768) begin
			r = 16'h8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	// ka*x + kb*y, each complex product rounded, sums saturated
	function automatic logic [31:0] kernel_mac(logic [31:0] ka, logic [31:0] x,
			logic [31:0] kb, logic [31:0] y);
		longint ar, ai, br, bi, xr, xi, yr, yi, re, im;
		ar = longint'($signed(ka[31:16]));
		ai = longint'($signed(ka[15:0]));
		br = longint'($signed(kb[31:16]));
		bi = longint'($signed(kb[15:0]));
		xr = longint'($signed(x[31:16]));
		xi = longint'($signed(x[15:0]));
		yr = longint'($signed(y[31:16]));
		yi = longint'($signed(y[15:0]));
		re = q14_round(ar * xr - ai * xi) + q14_round(br * yr - bi * yi);
		im = q14_round(ar * xi + ai * xr) + q14_round(br * yi + bi * yr);
		return {q14_clamp(re), q14_clamp(im)};
	endfunction

	function automatic bit pair_enabled(int lower, int ctl);
		return (ctl < 0) || (((lower >> ctl) & 1) != 0);
	endfunction

	function automatic gate_result_t execute_gate(gate_cmd_t c);
		gate_result_t res;
		int rows, cols, step, ctl, p, a, b;
		logic [31:0] e, f;
		res = '0;
		rows = (int'(row_limit_q) > STORE_ROWS) ? STORE_ROWS : int'(row_limit_q);
		cols = (int'(col_limit_q) > STORE_COLS) ? STORE_COLS : int'(col_limit_q);
		step = 1 << c.target;
		ctl = int'(c.control);
		case (c.op)
			CMD_WRITE: begin
				shadow_matrix[c.row * STORE_COLS + c.col] = {c.wre, c.wim};
			end
			CMD_READ: begin
				res.is_read = 1'b1;
				{res.re, res.im} = shadow_matrix[c.row * STORE_COLS + c.col];
			end
			CMD_LEFT: begin
				for (int i = 0; i < rows; i++) begin
					p = i + step;
					if ((i & step) == 0 && p < rows) begin
						for (int j = 0; j < cols; j++) begin
							a = i * STORE_COLS + j;
							b = p * STORE_COLS + j;
							e = shadow_matrix[a];
							f = shadow_matrix[b];
							if (pair_enabled(i, ctl)) begin
								shadow_matrix[a] = kernel_mac(kernel_q[REG_COEF_00], e,
									kernel_q[REG_COEF_01], f);
								shadow_matrix[b] = kernel_mac(kernel_q[REG_COEF_10], e,
									kernel_q[REG_COEF_11], f);
							end else if (c.deriv) begin
								shadow_matrix[a] = '0;
								shadow_matrix[b] = '0;
							end
						end
					end
				end
			end
			CMD_RIGHT: begin
				for (int j = 0; j < cols; j++) begin
					p = j + step;
					if ((j & step) == 0 && p < cols && pair_enabled(j, ctl)) begin
						for (int i = 0; i < rows; i++) begin
							a = i * STORE_COLS + j;
							b = i * STORE_COLS + p;
							e = shadow_matrix[a];
							f = shadow_matrix[b];
							shadow_matrix[a] = kernel_mac(kernel_q[REG_COEF_00], e,
								kernel_q[REG_COEF_10], f);
							shadow_matrix[b] = kernel_mac(kernel_q[REG_COEF_01], e,
								kernel_q[REG_COEF_11], f);
						end
					end
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Monitor: result check, then command transfer into the shadow model
	// ------------------------------------------------------------------
	always @(posedge clk) begin : watch_ports
		gate_cmd_t    taken;
		gate_result_t want;
		if (out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				flag_error($sformatf("unexpected result re=%0d im=%0d is_read=%0b",
					rd_re, rd_im, is_read));
			end else begin
				want = pending_results.pop_front();
				if (rd_re !== want.re || rd_im !== want.im || is_read !== want.is_read) begin
					flag_error($sformatf({"result mismatch: expected re=%0d im=%0d is_read=%0b,",
						" got re=%0d im=%0d is_read=%0b"}, want.re, want.im, want.is_read,
						rd_re, rd_im, is_read));
				end
			end
		end
		if (in_valid && in_ready) begin
			taken.op = cmd_t'(cmd);
			taken.row = row;
			taken.col = col;
			taken.wre = wr_re;
			taken.wim = wr_im;
			taken.target = target;
			taken.control = control;
			taken.deriv = deriv;
			pending_results.push_back(execute_gate(taken));
		end
		in_fire <= in_valid && in_ready;
	end

	// ------------------------------------------------------------------
	// Driver and receiver, both on the falling edge
	// ------------------------------------------------------------------
	always @(negedge clk) begin : feed_ports
		gate_cmd_t nxt;
		if (!in_valid || in_fire) begin
			if (send_gap > 0) begin
				in_valid <= 1'b0;
				send_gap--;
			end else if (gate_queue.size() > 0) begin
				nxt = gate_queue.pop_front();
				cmd <= nxt.op;
				row <= nxt.row;
				col <= nxt.col;
				wr_re <= nxt.wre;
				wr_im <= nxt.wim;
				target <= nxt.target;
				control <= nxt.control;
				deriv <= nxt.deriv;
				in_valid <= 1'b1;
				if (!quiet && $urandom_range(0, 5) == 0) begin
					send_gap = $urandom_range(1, 14);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else if (sink_gap > 0) begin
			out_ready <= 1'b0;
			sink_gap--;
		end else begin
			out_ready <= 1'b1;
			if (!quiet && $urandom_range(0, 7) == 0) begin
				sink_gap = $urandom_range(1, 14);
			end
		end
	end

	// ------------------------------------------------------------------
	// APB register access and phase control
	// ------------------------------------------------------------------
	task automatic write_reg(logic [2:0] idx, logic [31:0] value);
		logic [31:0] readback;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		readback = value;
		if (idx <= REG_COEF_11) begin
			kernel_q[idx[1:0]] = value;
		end else if (idx == REG_ROW_COUNT) begin
			row_limit_q = value[5:0];
			readback = {26'd0, value[5:0]};
		end else if (idx == REG_COL_COUNT) begin
			col_limit_q = value[5:0];
			readback = {26'd0, value[5:0]};
		end
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== readback) begin
			flag_error($sformatf("register %0d reads 0x%08h, expected 0x%08h", idx, prdata,
				readback));
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic wait_idle();
		while (gate_queue.size() != 0 || in_valid || pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	function automatic void queue_item(gate_cmd_t c);
		if (c.op == CMD_WRITE) begin
			written_map[c.row * STORE_COLS + c.col] = 1'b1;
		end
		gate_queue.push_back(c);
	endfunction

	function automatic void push_op(cmd_t op, int r, int c, logic [15:0] re, logic [15:0] im,
			int tgt, int ctl, bit drv);
		gate_cmd_t g;
		g.op = op;
		g.row = 5'(r);
		g.col = 5'(c);
		g.wre = re;
		g.wim = im;
		g.target = 3'(tgt);
		g.control = 4'(ctl);
		g.deriv = drv;
		queue_item(g);
	endfunction

	function automatic logic [15:0] random_part();
		logic [15:0] v;
		v = 16'($urandom());
		case ($urandom_range(0, 11))
			0: v = 16'h7FFF;
			1: v = 16'h8000;
			2: v = 16'h0000;
			3: v = 16'hFFFF;
			default: ;
		endcase
		return v;
	endfunction

	// kernel entry with parts in [-0.5, 0.5), keeps repeated applies in range
	function automatic logic [31:0] soft_coef();
		logic [15:0] re_part, im_part;
		re_part = 16'($urandom_range(0, 16383)) - 16'd8192;
		im_part = 16'($urandom_range(0, 16383)) - 16'd8192;
		return {re_part, im_part};
	endfunction

	function automatic int first_gap(int rows_eff, int cols_eff);
		for (int r = 0; r < rows_eff; r++) begin
			for (int c = 0; c < cols_eff; c++) begin
				if (!written_map[r * STORE_COLS + c]) begin
					return r * STORE_COLS + c;
				end
			end
		end
		return -1;
	endfunction

	function automatic int find_written(int rows_eff, int cols_eff);
		int r, c;
		for (int t = 0; t < 40; t++) begin
			if (t < 20 && rows_eff > 0 && cols_eff > 0) begin
				r = $urandom_range(0, rows_eff - 1);
				c = $urandom_range(0, cols_eff - 1);
			end else begin
				r = $urandom_range(0, STORE_ROWS - 1);
				c = $urandom_range(0, STORE_COLS - 1);
			end
			if (written_map[r * STORE_COLS + c]) begin
				return r * STORE_COLS + c;
			end
		end
		return -1;
	endfunction

	// applies only once the whole used area holds written entries
	task automatic add_random_items(int n_items);
		gate_cmd_t c;
		int rows_eff, cols_eff, pick, slot, hit;
		rows_eff = (int'(row_limit_q) > STORE_ROWS) ? STORE_ROWS : int'(row_limit_q);
		cols_eff = (int'(col_limit_q) > STORE_COLS) ? STORE_COLS : int'(col_limit_q);
		for (int k = 0; k < n_items; k++) begin
			c.row = 5'($urandom());
			c.col = 5'($urandom());
			c.wre = random_part();
			c.wim = random_part();
			c.target = 3'($urandom());
			c.control = 4'($urandom());
			c.deriv = 1'($urandom());
			pick = $urandom_range(0, 99);
			slot = first_gap(rows_eff, cols_eff);
			hit = (pick >= 30 && pick < 55) ? find_written(rows_eff, cols_eff) : -1;
			if (pick >= 55 && slot < 0) begin
				c.op = $urandom_range(0, 1) ? CMD_LEFT : CMD_RIGHT;
				if ($urandom_range(0, 3) != 0) begin
					c.target = 3'($urandom_range(0, 4));
				end
				case ($urandom_range(0, 9)) inside
					0, 1, 2, 3: c.control = -4'sd1;
					4, 5, 6, 7: c.control = 4'($urandom_range(0, 4));
					default: ;
				endcase
			end else if (hit >= 0) begin
				c.op = CMD_READ;
				c.row = 5'(hit / STORE_COLS);
				c.col = 5'(hit % STORE_COLS);
			end else begin
				c.op = CMD_WRITE;
				if (slot >= 0) begin
					c.row = 5'(slot / STORE_COLS);
					c.col = 5'(slot % STORE_COLS);
				end else if (rows_eff > 0 && cols_eff > 0 && $urandom_range(0, 4) != 0) begin
					c.row = 5'($urandom_range(0, rows_eff - 1));
					c.col = 5'($urandom_range(0, cols_eff - 1));
				end
			end
			queue_item(c);
		end
	endtask

	task automatic run_phase(logic [31:0] k00, logic [31:0] k01, logic [31:0] k10,
			logic [31:0] k11, logic [5:0] rows, logic [5:0] cols, int n_items);
		wait_idle();
		write_reg(REG_COEF_00, k00);
		write_reg(REG_COEF_01, k01);
		write_reg(REG_COEF_10, k10);
		write_reg(REG_COEF_11, k11);
		write_reg(REG_ROW_COUNT, {26'd0, rows});
		write_reg(REG_COL_COUNT, {26'd0, cols});
		add_random_items(n_items);
	endtask

	initial begin
		kernel_q[REG_COEF_00] = COEF_ONE;
		kernel_q[REG_COEF_01] = '0;
		kernel_q[REG_COEF_10] = '0;
		kernel_q[REG_COEF_11] = COEF_ONE;
		row_limit_q = COUNT_RST;
		col_limit_q = COUNT_RST;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// 2x2 area with a saturating kernel
		run_phase(32'h7FFF_7FFF, 32'h8000_8000, 32'h2D41_0000, 32'h0000_D2BF, 6'd2, 6'd2, 0);
		push_op(CMD_WRITE, 0, 0, 16'h7FFF, 16'h7FFF, 0, 0, 0);
		push_op(CMD_WRITE, 0, 1, 16'h8000, 16'h8000, 0, 0, 0);
		push_op(CMD_WRITE, 1, 0, 16'h8000, 16'h7FFF, 0, 0, 0);
		push_op(CMD_WRITE, 1, 1, 16'h0000, 16'hFFFF, 0, 0, 0);
		push_op(CMD_WRITE, 31, 31, 16'h7FFF, 16'h8000, 7, -1, 1);
		push_op(CMD_WRITE, 31, 0, 16'hFFFF, 16'h0001, 0, 0, 0);
		push_op(CMD_WRITE, 0, 31, 16'h0000, 16'h0000, 0, 0, 0);
		push_op(CMD_READ, 31, 31, 16'h0000, 16'h0000, 0, 0, 0);
		push_op(CMD_READ, 1, 1, 16'hFFFF, 16'hFFFF, 7, 7, 1);
		push_op(CMD_LEFT, 0, 0, 16'h0000, 16'h0000, 0, -1, 0);
		push_op(CMD_READ, 0, 0, 16'h0000, 16'h0000, 0, 0, 0);
		// deriv has no effect from the right
		push_op(CMD_RIGHT, 0, 0, 16'h0000, 16'h0000, 0, -1, 1);
		push_op(CMD_READ, 0, 1, 16'h0000, 16'h0000, 0, 0, 0);
		// target beyond the used rows: no pair
		push_op(CMD_LEFT, 0, 0, 16'h0000, 16'h0000, 1, -1, 0);
		push_op(CMD_LEFT, 0, 0, 16'h0000, 16'h0000, 7, 7, 1);
		// control on the target bit: nothing updated, but a negative control (-8) updates the pair
		push_op(CMD_LEFT, 0, 0, 16'h0000, 16'h0000, 0, 0, 0);
		push_op(CMD_RIGHT, 0, 0, 16'h0000, 16'h0000, 0, 0, 1);
		push_op(CMD_LEFT, 0, 0, 16'h0000, 16'h0000, 0, -8, 0);
		push_op(CMD_READ, 1, 0, 16'h0000, 16'h0000, 0, 0, 0);
		// same with deriv: all pairs cleared
		push_op(CMD_LEFT, 0, 0, 16'h0000, 16'h0000, 0, 0, 1);
		push_op(CMD_READ, 1, 1, 16'h0000, 16'h0000, 0, 0, 0);

		run_phase(soft_coef(), soft_coef(), soft_coef(), soft_coef(), 6'd4, 6'd4, 60);
		hold_requests++;
		run_phase($urandom(), $urandom(), $urandom(), $urandom(), 6'd32, 6'd1, 60);
		run_phase(soft_coef(), soft_coef(), soft_coef(), soft_coef(), 6'd1, 6'd32, 60);
		run_phase(32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_8000, 32'h7FFF_7FFF, 6'd0, 6'd63, 40);
		run_phase(32'h2D41_0000, 32'h2D41_0000, 32'h2D41_0000, 32'hD2BF_0000, 6'd63, 6'd2, 60);
		run_phase(soft_coef(), soft_coef(), soft_coef(), soft_coef(), 6'd8, 6'd8, 60);
		run_phase($urandom(), $urandom(), $urandom(), $urandom(), 6'd16, 6'd5, 60);
		run_phase(soft_coef(), soft_coef(), soft_coef(), soft_coef(), 6'd3, 6'd7, 60);
		wait_idle();
		quiet = 1'b1;
		run_phase(soft_coef(), soft_coef(), soft_coef(), soft_coef(), 6'd8, 6'd8, 60);

		wait_idle();
		repeat (20) @(posedge clk);
		if (pending_results.size() != 0) begin
			flag_error($sformatf("%0d results never arrived", pending_results.size()));
		end
		if (error_count == 0) begin
			$display("controlled_qubit_gate_matrix_update regression: pass");
		end else begin
			$display("controlled_qubit_gate_matrix_update regression: fail");
		end
		$finish;
	end

endmodule

// ===== controlled_qubit_gate_matrix_update.f =====
design/cqg_pkg.sv
design/cqg_ram.sv
design/controlled_qubit_gate_matrix_update.sv
design/cqg_chk.sv
sim/controlled_qubit_gate_matrix_update_test.sv
